FILE: src/iase_pkg.sv
// Shared types, constants and digit helpers for the IMU average sentence encoder.
// Used by the sentence emitter, the top level and the test bench.
// Depends on nothing.
package iase_pkg;

  localparam int SAMPLES_PER_GROUP = 5;
  localparam int NUM_CH = 6;
  localparam int SUM_W = 19;
  localparam int SAMPLE_W = 16;

  localparam int DIV_SHIFT = 21;
  localparam int RECIP_W = 21;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_SHIFT) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP);
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int HDR_LEN = 7;
  localparam int TIME_LEN = 11;

  localparam logic [7:0] ASC_DOLLAR = 8'h24;
  localparam logic [7:0] ASC_STAR = 8'h2A;
  localparam logic [7:0] ASC_COMMA = 8'h2C;
  localparam logic [7:0] ASC_DOT = 8'h2E;
  localparam logic [7:0] ASC_ZERO = 8'h30;
  localparam logic [7:0] ASC_A = 8'h41;
  localparam logic [7:0] ASC_CR = 8'h0D;
  localparam logic [7:0] ASC_LF = 8'h0A;

  localparam logic [7:0] HDR_BYTES [HDR_LEN] =
    '{ASC_DOLLAR, 8'h47, 8'h50, 8'h49, 8'h4D, 8'h55, ASC_COMMA};

  typedef struct packed {
    logic [NUM_CH-1:0][SAMPLE_W-1:0] avg;
    logic [7:0] seq;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } sentence_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib <= 4'd9) ? (ASC_ZERO + {4'h0, nib}) : (ASC_A + {4'h0, nib} - 8'd10);
  endfunction

  function automatic logic [3:0] tens_6(input logic [5:0] v);
    logic [16:0] p;
    p = 17'(v) * 17'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_6(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(tens_6(v)) * 6'd10;
    return r[3:0];
  endfunction

  function automatic logic [3:0] ms_hundreds(input logic [9:0] ms);
    logic [15:0] p;
    p = 16'(ms) * 16'd41;
    return p[15:12];
  endfunction

  function automatic logic [6:0] ms_div10(input logic [9:0] ms);
    logic [17:0] p;
    p = 18'(ms) * 18'd205;
    return p[17:11];
  endfunction

  function automatic logic [3:0] ms_tens(input logic [9:0] ms);
    logic [6:0] q10;
    logic [14:0] p;
    logic [6:0] r;
    q10 = ms_div10(ms);
    p = 15'(q10) * 15'd205;
    r = q10 - 7'(p[14:11]) * 7'd10;
    return r[3:0];
  endfunction

  function automatic logic [3:0] ms_ones(input logic [9:0] ms);
    logic [9:0] r;
    r = ms - 10'(ms_div10(ms)) * 10'd10;
    return r[3:0];
  endfunction

endpackage

FILE: src/iase_in_if.sv
// Input channel of the IMU average sentence encoder: one six-channel sample per transaction.
// Carries valid, ready and the sample payload; no package dependency.
interface iase_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] accel_pitch;
  logic signed [15:0] accel_roll;
  logic signed [15:0] accel_vertical;
  logic [7:0] sequence_number;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [9:0] millisecond;

  modport source (
    output valid, gyro_x, gyro_y, gyro_z, accel_pitch, accel_roll, accel_vertical,
    output sequence_number, hour, minute, second, millisecond,
    input ready
  );
  modport sink (
    input valid, gyro_x, gyro_y, gyro_z, accel_pitch, accel_roll, accel_vertical,
    input sequence_number, hour, minute, second, millisecond,
    output ready
  );
endinterface

FILE: src/iase_out_if.sv
// Result channel of the IMU average sentence encoder: one sentence byte per transaction.
// Carries valid, ready and the byte payload; no package dependency.
interface iase_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

FILE: src/iase_emitter.sv
// Sentence emitter: walks the sentence fields, builds each ASCII byte and the XOR checksum.
// Depends on iase_pkg and iase_out_if; the byte leaves through an output register.
module iase_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 time_enable,
  input  iase_pkg::sentence_t  sent,
  output logic                 busy,
  iase_out_if.source           out_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HDR  = 4'd1;
  localparam logic [3:0] S_TIME = 4'd2;
  localparam logic [3:0] S_AVG  = 4'd3;
  localparam logic [3:0] S_SEQ  = 4'd4;
  localparam logic [3:0] S_STAR = 4'd5;
  localparam logic [3:0] S_CK   = 4'd6;
  localparam logic [3:0] S_CR   = 4'd7;
  localparam logic [3:0] S_LF   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [2:0] ch_r, ch_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       load;
  logic [7:0] byte_c;
  logic [15:0] avg_word;
  logic [3:0] nib;

  assign load = (state_r != S_IDLE) && (!out_valid_r || out_ch.ready);
  assign busy = (state_r != S_IDLE);
  assign avg_word = sent.avg[ch_r];

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    nib = avg_word[15:12];
      2'd1:    nib = avg_word[11:8];
      2'd2:    nib = avg_word[7:4];
      default: nib = avg_word[3:0];
    endcase
  end

  always_comb begin
    byte_c = iase_pkg::ASC_COMMA;
    unique case (state_r)
      S_HDR: byte_c = iase_pkg::HDR_BYTES[cnt_r[2:0]];
      S_TIME: begin
        case (cnt_r)
          4'd0:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::tens_6({1'b0, sent.hour})};
          4'd1:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::ones_6({1'b0, sent.hour})};
          4'd2:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::tens_6(sent.minute)};
          4'd3:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::ones_6(sent.minute)};
          4'd4:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::tens_6(sent.second)};
          4'd5:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::ones_6(sent.second)};
          4'd6:    byte_c = iase_pkg::ASC_DOT;
          4'd7:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::ms_hundreds(sent.millisecond)};
          4'd8:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::ms_tens(sent.millisecond)};
          4'd9:    byte_c = iase_pkg::ASC_ZERO + {4'h0, iase_pkg::ms_ones(sent.millisecond)};
          default: byte_c = iase_pkg::ASC_COMMA;
        endcase
      end
      S_AVG: byte_c = (cnt_r == 4'd4) ? iase_pkg::ASC_COMMA : iase_pkg::hex_char(nib);
      S_SEQ: byte_c = iase_pkg::hex_char((cnt_r == 4'd0) ? sent.seq[7:4] : sent.seq[3:0]);
      S_STAR: byte_c = iase_pkg::ASC_STAR;
      S_CK: byte_c = iase_pkg::hex_char((cnt_r == 4'd0) ? chk_r[7:4] : chk_r[3:0]);
      S_CR: byte_c = iase_pkg::ASC_CR;
      S_LF: byte_c = iase_pkg::ASC_LF;
      default: byte_c = iase_pkg::ASC_COMMA;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ch_nxt = ch_r;
    chk_nxt = chk_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_IDLE) begin
      if (start) begin
        state_nxt = S_HDR;
        cnt_nxt = '0;
        ch_nxt = '0;
        chk_nxt = '0;
      end
    end else if (load) begin
      out_valid_nxt = 1'b1;
      cnt_nxt = cnt_r + 4'd1;
      if ((state_r == S_HDR && cnt_r != 4'd0) || state_r == S_TIME ||
          state_r == S_AVG || state_r == S_SEQ) begin
        chk_nxt = chk_r ^ byte_c;
      end
      unique case (state_r)
        S_HDR: begin
          if (cnt_r == 4'(iase_pkg::HDR_LEN - 1)) begin
            cnt_nxt = '0;
            state_nxt = time_enable ? S_TIME : S_AVG;
          end
        end
        S_TIME: begin
          if (cnt_r == 4'(iase_pkg::TIME_LEN - 1)) begin
            cnt_nxt = '0;
            state_nxt = S_AVG;
          end
        end
        S_AVG: begin
          if (cnt_r == 4'd4) begin
            cnt_nxt = '0;
            ch_nxt = ch_r + 3'd1;
            if (ch_r == 3'(iase_pkg::NUM_CH - 1)) begin
              state_nxt = S_SEQ;
            end
          end
        end
        S_SEQ: begin
          if (cnt_r == 4'd1) begin
            cnt_nxt = '0;
            state_nxt = S_STAR;
          end
        end
        S_STAR: begin
          cnt_nxt = '0;
          state_nxt = S_CK;
        end
        S_CK: begin
          if (cnt_r == 4'd1) begin
            cnt_nxt = '0;
            state_nxt = S_CR;
          end
        end
        S_CR: state_nxt = S_LF;
        S_LF: state_nxt = S_IDLE;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ch_r <= '0;
      chk_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ch_r <= ch_nxt;
      chk_r <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_c;
      out_last_r <= (state_r == S_LF);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  a_start_enters_header: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_HDR && cnt_r == 4'd0))
    else $error("sentence did not start with the header");
  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_byte_r == iase_pkg::ASC_LF))
    else $error("last byte flag on a byte other than LF");
  a_lf_ends_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    (load && state_r == S_LF) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("sentence did not end after LF");

endmodule

FILE: src/imu_average_ascii_sentence_encoder.sv
// IMU average sentence encoder top level: sample accumulation, group averaging, sentence emit.
// Depends on iase_pkg, iase_in_if, iase_out_if and iase_emitter.
//
// Usage: in_ch takes one six-channel sample per transaction. Every sample is added
// into six 19-bit running sums by one shared adder, one channel per cycle, and the
// channel is not ready again until all six sums are updated. The fifth sample of a
// group closes it: one multiplier, shared over the channels, turns each sum into its
// average (reciprocal multiply), the sums are cleared and the emitter writes the
// sentence on out_ch, one byte per cycle while out_ch.ready is high. A sentence has
// 44 bytes, or 55 with time enabled, and last_byte marks its LF. in_ch is not ready
// while a sentence is being built; it becomes ready once LF sits in the output
// register. A stalled receiver holds the current byte and the sequencer waits.
// cfg_we writes time_enable from cfg_wdata; write it only while idle. Reset clears
// the sums, the sample count, time_enable and the sequencer state; the sample and
// sentence registers are not reset.
module imu_average_ascii_sentence_encoder (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  iase_in_if.sink   in_ch,
  iase_out_if.source out_ch
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_ACC   = 2'd1;
  localparam logic [1:0] T_DIV   = 2'd2;
  localparam logic [1:0] T_START = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] count_r, count_nxt;
  logic       time_enable_r;
  logic signed [iase_pkg::SUM_W-1:0] sums_r [iase_pkg::NUM_CH];
  logic signed [iase_pkg::SAMPLE_W-1:0] smp_r [iase_pkg::NUM_CH];
  logic [iase_pkg::PROD_W-1:0] prod_r;
  logic neg_r;
  iase_pkg::sentence_t sent_r;
  logic accept;
  logic emit_start;
  logic emit_busy;
  logic signed [iase_pkg::SUM_W-1:0] sum_sel;
  logic [iase_pkg::SUM_W-1:0] mag;
  logic [iase_pkg::SAMPLE_W-1:0] q16;

  assign in_ch.ready = (state_r == T_IDLE) && !emit_busy;
  assign accept = in_ch.valid && in_ch.ready;
  assign emit_start = (state_r == T_START);

  assign sum_sel = (k_r < 3'(iase_pkg::NUM_CH)) ? sums_r[k_r] : '0;
  assign mag = sum_sel[iase_pkg::SUM_W-1] ? iase_pkg::SUM_W'(-sum_sel)
                                          : iase_pkg::SUM_W'(sum_sel);
  assign q16 = prod_r[iase_pkg::DIV_SHIFT +: iase_pkg::SAMPLE_W];

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    count_nxt = count_r;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = T_ACC;
          k_nxt = '0;
        end
      end
      T_ACC: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'(iase_pkg::NUM_CH - 1)) begin
          k_nxt = '0;
          if (count_r == 3'(iase_pkg::SAMPLES_PER_GROUP - 1)) begin
            count_nxt = '0;
            state_nxt = T_DIV;
          end else begin
            count_nxt = count_r + 3'd1;
            state_nxt = T_IDLE;
          end
        end
      end
      T_DIV: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'(iase_pkg::NUM_CH)) begin
          k_nxt = '0;
          state_nxt = T_START;
        end
      end
      T_START: state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      k_r <= '0;
      count_r <= '0;
      time_enable_r <= 1'b0;
      for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
        sums_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        time_enable_r <= cfg_wdata;
      end
      if (state_r == T_ACC) begin
        sums_r[k_r] <= sums_r[k_r] +
          {{(iase_pkg::SUM_W - iase_pkg::SAMPLE_W){smp_r[k_r][iase_pkg::SAMPLE_W-1]}},
           smp_r[k_r]};
      end
      if (state_r == T_DIV && k_r == 3'(iase_pkg::NUM_CH)) begin
        for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
          sums_r[c] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r[0] <= in_ch.gyro_x;
      smp_r[1] <= in_ch.gyro_y;
      smp_r[2] <= in_ch.gyro_z;
      smp_r[3] <= in_ch.accel_pitch;
      smp_r[4] <= in_ch.accel_roll;
      smp_r[5] <= in_ch.accel_vertical;
      sent_r.seq <= in_ch.sequence_number;
      sent_r.hour <= in_ch.hour;
      sent_r.minute <= in_ch.minute;
      sent_r.second <= in_ch.second;
      sent_r.millisecond <= in_ch.millisecond;
    end
    if (state_r == T_DIV) begin
      prod_r <= iase_pkg::PROD_W'(mag) * iase_pkg::PROD_W'(iase_pkg::RECIP);
      neg_r <= sum_sel[iase_pkg::SUM_W-1];
      if (k_r != 3'd0) begin
        sent_r.avg[k_r - 3'd1] <= neg_r ? (~q16 + 16'd1) : q16;
      end
    end
  end

  iase_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (emit_start),
    .time_enable (time_enable_r),
    .sent        (sent_r),
    .busy        (emit_busy),
    .out_ch      (out_ch)
  );

  a_accept_starts_acc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == T_ACC && k_r == 3'd0))
    else $error("accepted sample did not start accumulation");
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < 3'(iase_pkg::SAMPLES_PER_GROUP))
    else $error("sample count passed the group size");
  a_div_while_idle_emitter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_DIV || emit_start) |-> !emit_busy)
    else $error("averages changed while a sentence was being emitted");
  a_start_follows_div: assert property (@(posedge clk) disable iff (!rst_n)
    emit_start |-> $past(state_r == T_DIV))
    else $error("sentence start without averaging");

endmodule

FILE: tb/imu_average_ascii_sentence_encoder_test.sv
// Self-checking test of the IMU average sentence encoder: six-channel samples in, ASCII bytes out.
// Predicts each sentence from its own copy of the group sums and compares every transaction.
// Depends on iase_pkg, iase_in_if, iase_out_if and imu_average_ascii_sentence_encoder.
module imu_average_ascii_sentence_encoder_test;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [iase_pkg::NUM_CH-1:0][15:0] ch;
    logic [7:0] seq;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] msec;
  } imu_sample_t;

  typedef struct packed {
    logic [7:0] data;
    logic last;
  } sentence_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  iase_in_if in_ch ();
  iase_out_if out_ch ();

  imu_average_ascii_sentence_encoder u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  int group_sums [iase_pkg::NUM_CH];
  int group_count;
  logic time_en_model;
  sentence_byte_t expected_sentence_q [$];
  sentence_byte_t next_expected;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_requests;
  int hold_off_served;
  int hold_off_left;

  int mismatches;
  int samples_sent;
  int bytes_checked;
  int sentences_checked;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] nibble_to_ascii(input int n);
    return (n < 10) ? 8'(iase_pkg::ASC_ZERO + n) : 8'(iase_pkg::ASC_A + n - 10);
  endfunction

  function automatic logic [7:0] digit_to_ascii(input int d);
    return 8'(iase_pkg::ASC_ZERO + d);
  endfunction

  function automatic void accumulate_sample(input imu_sample_t s);
    logic [7:0] text [$];
    string tag;
    logic [7:0] chk;
    int avg;
    int hh;
    int mi;
    int ss;
    int ms;
    tag = "GPIMU";
    for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
      group_sums[c] += int'($signed(s.ch[c]));
    end
    group_count++;
    if (group_count < iase_pkg::SAMPLES_PER_GROUP) begin
      return;
    end
    text.push_back(iase_pkg::ASC_DOLLAR);
    for (int i = 0; i < tag.len(); i++) begin
      text.push_back(tag[i]);
    end
    text.push_back(iase_pkg::ASC_COMMA);
    if (time_en_model) begin
      hh = int'(s.hour);
      mi = int'(s.minute);
      ss = int'(s.second);
      ms = int'(s.msec);
      text.push_back(digit_to_ascii(hh / 10));
      text.push_back(digit_to_ascii(hh % 10));
      text.push_back(digit_to_ascii(mi / 10));
      text.push_back(digit_to_ascii(mi % 10));
      text.push_back(digit_to_ascii(ss / 10));
      text.push_back(digit_to_ascii(ss % 10));
      text.push_back(iase_pkg::ASC_DOT);
      text.push_back(digit_to_ascii(ms / 100));
      text.push_back(digit_to_ascii((ms / 10) % 10));
      text.push_back(digit_to_ascii(ms % 10));
      text.push_back(iase_pkg::ASC_COMMA);
    end
    for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
      avg = group_sums[c] / iase_pkg::SAMPLES_PER_GROUP;
      text.push_back(nibble_to_ascii(int'(avg[15:12])));
      text.push_back(nibble_to_ascii(int'(avg[11:8])));
      text.push_back(nibble_to_ascii(int'(avg[7:4])));
      text.push_back(nibble_to_ascii(int'(avg[3:0])));
      text.push_back(iase_pkg::ASC_COMMA);
    end
    text.push_back(nibble_to_ascii(int'(s.seq[7:4])));
    text.push_back(nibble_to_ascii(int'(s.seq[3:0])));
    chk = 8'h00;
    for (int i = 1; i < text.size(); i++) begin
      chk ^= text[i];
    end
    text.push_back(iase_pkg::ASC_STAR);
    text.push_back(nibble_to_ascii(int'(chk[7:4])));
    text.push_back(nibble_to_ascii(int'(chk[3:0])));
    text.push_back(iase_pkg::ASC_CR);
    text.push_back(iase_pkg::ASC_LF);
    for (int i = 0; i < text.size(); i++) begin
      expected_sentence_q.push_back('{data: text[i], last: (i == text.size() - 1)});
    end
    for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
      group_sums[c] = 0;
    end
    group_count = 0;
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
      case ($urandom_range(9))
        0: s.ch[c] = 16'h7FFF;
        1: s.ch[c] = 16'h8000;
        2: s.ch[c] = 16'($urandom_range(15)) - 16'd8;
        default: s.ch[c] = 16'($urandom);
      endcase
    end
    s.seq = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      s.hour = 5'($urandom);
      s.minute = 6'($urandom);
      s.second = 6'($urandom);
      s.msec = 10'($urandom);
    end else begin
      s.hour = 5'($urandom_range(23));
      s.minute = 6'($urandom_range(59));
      s.second = 6'($urandom_range(59));
      s.msec = 10'($urandom_range(999));
    end
    return s;
  endfunction

  task automatic send_sample(input imu_sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.gyro_x <= s.ch[0];
    in_ch.gyro_y <= s.ch[1];
    in_ch.gyro_z <= s.ch[2];
    in_ch.accel_pitch <= s.ch[3];
    in_ch.accel_roll <= s.ch[4];
    in_ch.accel_vertical <= s.ch[5];
    in_ch.sequence_number <= s.seq;
    in_ch.hour <= s.hour;
    in_ch.minute <= s.minute;
    in_ch.second <= s.second;
    in_ch.millisecond <= s.msec;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    accumulate_sample(s);
    samples_sent++;
  endtask

  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    while (expected_sentence_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_time_enable(input logic value);
    wait_until_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    time_en_model = value;
  endtask

  task automatic test_channel_extremes();
    imu_sample_t s;
    s = '0;
    s.ch = {iase_pkg::NUM_CH{16'h7FFF}};
    s.seq = 8'hFF;
    repeat (iase_pkg::SAMPLES_PER_GROUP) send_sample(s);
    s.ch = {iase_pkg::NUM_CH{16'h8000}};
    s.seq = 8'h00;
    repeat (iase_pkg::SAMPLES_PER_GROUP) send_sample(s);
  endtask

  task automatic test_time_field();
    imu_sample_t s;
    write_time_enable(1'b1);
    s = '0;
    s.seq = 8'hA5;
    s.hour = 5'd31;
    s.minute = 6'd63;
    s.second = 6'd63;
    s.msec = 10'd1023;
    for (int k = 0; k < iase_pkg::SAMPLES_PER_GROUP; k++) begin
      s.ch[0] = (k == 0) ? -16'sd3 : (k == 1) ? -16'sd4 : 16'd0;
      s.ch[1] = (k == 0) ? 16'd3 : (k == 1) ? 16'd4 : 16'd0;
      s.ch[2] = (k < 4) ? 16'hFFFF : 16'd0;
      s.ch[3] = (k < 4) ? 16'd1 : 16'd0;
      s.ch[4] = (k == 4) ? 16'h8000 : 16'h7FFF;
      s.ch[5] = 16'(-(k + 1) * 1000);
      send_sample(s);
    end
    s = '0;
    s.seq = 8'h5A;
    s.hour = 5'd23;
    s.minute = 6'd59;
    s.second = 6'd59;
    s.msec = 10'd999;
    repeat (iase_pkg::SAMPLES_PER_GROUP) send_sample(s);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_sample(random_sample());
  endtask

  task automatic test_output_backpressure();
    hold_off_requests++;
    repeat (3 * iase_pkg::SAMPLES_PER_GROUP) send_sample(random_sample());
  endtask

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_off_requests != hold_off_served) begin
      hold_off_served <= hold_off_served + 1;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_sentence_q.size() == 0) begin
        $display("%0t: unexpected transaction: byte %h last %b", $time,
                 out_ch.out_byte, out_ch.last_byte);
        mismatches++;
      end else begin
        next_expected = expected_sentence_q.pop_front();
        if (out_ch.out_byte !== next_expected.data) begin
          $display("%0t: out_byte expected %h actual %h", $time,
                   next_expected.data, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.last_byte !== next_expected.last) begin
          $display("%0t: last_byte expected %b actual %b", $time,
                   next_expected.last, out_ch.last_byte);
          mismatches++;
        end
        bytes_checked++;
        if (next_expected.last) begin
          sentences_checked++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.gyro_x = '0;
    in_ch.gyro_y = '0;
    in_ch.gyro_z = '0;
    in_ch.accel_pitch = '0;
    in_ch.accel_roll = '0;
    in_ch.accel_vertical = '0;
    in_ch.sequence_number = '0;
    in_ch.hour = '0;
    in_ch.minute = '0;
    in_ch.second = '0;
    in_ch.millisecond = '0;
    out_ch.ready = 1'b0;
    for (int c = 0; c < iase_pkg::NUM_CH; c++) begin
      group_sums[c] = 0;
    end
    group_count = 0;
    time_en_model = 1'b0;
    hold_off_requests = 0;
    hold_off_served = 0;
    hold_off_left = 0;
    mismatches = 0;
    samples_sent = 0;
    bytes_checked = 0;
    sentences_checked = 0;
    send_idle_pct = 37;
    recv_idle_pct = 85;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_channel_extremes();
    test_time_field();
    test_random_traffic(135);

    send_idle_pct = 85;
    recv_idle_pct = 37;
    write_time_enable(1'b0);
    test_random_traffic(135);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_time_enable(1'b1);
    test_output_backpressure();
    test_random_traffic(50);
    write_time_enable(1'b0);
    test_random_traffic(50);

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples; checked %0d bytes in %0d sentences, with and without time,",
             samples_sent, bytes_checked, sentences_checked);
    $display("under random stalls on both sides and one long output hold-off.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/iase_pkg.sv
src/iase_in_if.sv
src/iase_out_if.sv
src/iase_emitter.sv
src/imu_average_ascii_sentence_encoder.sv
tb/imu_average_ascii_sentence_encoder_test.sv
